>>> rtl/mash_pkg.sv
// Package for the multi-axis stepper homing core: widths, command and register codes,
// reset values, the saturation helper and the field helper. Depends on nothing; every RTL file imports it.
`default_nettype none

package mash_pkg;

   // Width of the position and target counters (valid range 16 to 32).
   localparam int POSITION_BITS = 18;

   localparam int NUM_AXES    = 5;   // stepper axes
   localparam int NUM_TARGETS = 6;   // stepper axes plus the servo channel
   localparam int SERVO_AXIS  = 5;

   localparam int CMD_BITS   = 2;
   localparam int AXIS_BITS  = 3;
   localparam int FIELD_BITS = 18;   // width of value, registers and servo_angle
   localparam int CSR_IDX_BITS = 3;

   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 40;

   // Wide enough to hold any position width and the 18-bit fields with a sign bit.
   localparam int EXT_BITS = 33;

   typedef logic signed [POSITION_BITS-1:0] position_type;
   typedef logic signed [FIELD_BITS-1:0]    field_type;
   typedef logic signed [EXT_BITS-1:0]      ext_type;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_TICK   = 2'd0,
      CMD_SET    = 2'd1,
      CMD_HOME   = 2'd2,
      CMD_LIMIT  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_HOME_AXIS0 = 3'd0,
      REG_HOME_AXIS1 = 3'd1,
      REG_HOME_AXIS2 = 3'd2,
      REG_HOME_AXIS3 = 3'd3,
      REG_HOME_AXIS4 = 3'd4,
      REG_SEEK_TARGET = 3'd5
   } csr_index_type;

   localparam ext_type POS_MAX = (ext_type'(1) <<< (POSITION_BITS - 1)) - ext_type'(1);
   localparam ext_type POS_MIN = -POS_MAX - ext_type'(1);

   localparam field_type HOME0_RESET = 18'sd0;
   localparam field_type HOME1_RESET = 18'sd10;
   localparam field_type HOME2_RESET = 18'sd0;
   localparam field_type HOME3_RESET = 18'sd300;
   localparam field_type HOME4_RESET = 18'sd1600;
   localparam field_type SEEK_RESET  = -18'sd90000;

   // Saturates an 18-bit field value into the position range.
   function automatic position_type clamp_pos(input field_type v);
      ext_type x;
      ext_type r;
      x = ext_type'(v);
      if (x > POS_MAX) begin
         r = POS_MAX;
      end else if (x < POS_MIN) begin
         r = POS_MIN;
      end else begin
         r = x;
      end
      return r[POSITION_BITS-1:0];
   endfunction

   // Low 18 bits of a position value, as sent on the servo field.
   function automatic field_type to_field(input position_type p);
      ext_type x;
      x = ext_type'(p);
      return x[FIELD_BITS-1:0];
   endfunction

   // One result item, first field in the highest bits.
   typedef struct packed {
      logic [4:0] moving_mask;
      logic [4:0] calibrated_mask;
      field_type  servo_angle;
      logic [4:0] dir_mask;
      logic [1:0] m5_pulses;
      logic       m4_pulses;
      logic [1:0] m3_pulses;
      logic       m2_pulses;
      logic       m1_pulses;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/multi_axis_stepper_homing_core.sv
// Top level of the five-axis stepper position tracker with limit-switch homing.
// Uses mash_pkg for widths, command codes, register codes and clamping helpers.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_tvalid/tready     req_tdata: cmd, axis, value
//   rsp      out        rsp_tvalid/tready     rsp_tdata: pulses, masks, servo angle
//   csr      in         csr_we                csr_index, csr_wdata (no read-back)
//
// Each transfer on req is latched into an input register and worked off by the
// compare-and-step logic, which updates the axis state and loads the result
// register at the same edge. One item per cycle is sustained while rsp is ready; the
// result passes from the input register through the result register to rsp and
// transfers when rsp_tready is high. A stalled rsp holds its result while one further
// item waits in the input register, after which req_tready drops.
// Reset is synchronous and active high; it restores the register reset values and
// the axis state (targets and positions zero, all axes calibrated, pins low).
`default_nettype none

module multi_axis_stepper_homing_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // Input stream.
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // From bit 0: cmd[1:0], axis[4:2], value[22:5], zero pad[23].
   input  wire logic [mash_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   // Result stream.
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // From bit 0: m1_pulses[0], m2_pulses[1], m3_pulses[3:2], m4_pulses[4],
   // m5_pulses[6:5], dir_mask[11:7], servo_angle[29:12], calibrated_mask[34:30],
   // moving_mask[39:35].
   output logic [mash_pkg::RSP_DATA_BITS-1:0]          rsp_tdata,
   // Register write port.
   input  wire logic                                   csr_we,
   input  wire logic [mash_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  wire logic [mash_pkg::FIELD_BITS-1:0]        csr_wdata
);
   import mash_pkg::*;

   // Configuration registers, held already clamped to the position range.
   position_type home_ff [NUM_AXES];
   position_type seek_ff;

   // Axis state.
   position_type target_ff   [NUM_TARGETS];
   position_type position_ff [NUM_AXES];
   logic [NUM_AXES-1:0] cal_ff;
   logic [NUM_AXES-1:0] dir_ff;

   position_type target_in   [NUM_TARGETS];
   position_type position_in [NUM_AXES];
   logic [NUM_AXES-1:0] cal_in;
   logic [NUM_AXES-1:0] dir_in;

   // Input register.
   logic                 s1_valid_ff;
   cmd_type              s1_cmd_ff;
   logic [AXIS_BITS-1:0] s1_axis_ff;
   field_type            s1_value_ff;

   // Result register.
   logic    out_valid_ff;
   rsp_type out_ff;
   rsp_type out_in;

   logic out_free;
   logic advance;
   logic req_xfer;
   logic [NUM_AXES-1:0] moving;
   logic [NUM_AXES-1:0] up_dir;

   // The result register frees up when it is empty or its transfer completes; the
   // input register then drains into it, so a new item can enter every cycle while rsp is ready.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_xfer) begin
         s1_cmd_ff   <= cmd_type'(req_tdata[1:0]);
         s1_axis_ff  <= req_tdata[4:2];
         s1_value_ff <= req_tdata[22:5];
      end
   end

   // Configuration writes land directly; the user must make them only while the core is idle (unchecked).
   always_ff @(posedge clock) begin
      if (reset) begin
         home_ff[0] <= clamp_pos(HOME0_RESET);
         home_ff[1] <= clamp_pos(HOME1_RESET);
         home_ff[2] <= clamp_pos(HOME2_RESET);
         home_ff[3] <= clamp_pos(HOME3_RESET);
         home_ff[4] <= clamp_pos(HOME4_RESET);
         seek_ff    <= clamp_pos(SEEK_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_HOME_AXIS0:  home_ff[0] <= clamp_pos(csr_wdata);
            REG_HOME_AXIS1:  home_ff[1] <= clamp_pos(csr_wdata);
            REG_HOME_AXIS2:  home_ff[2] <= clamp_pos(csr_wdata);
            REG_HOME_AXIS3:  home_ff[3] <= clamp_pos(csr_wdata);
            REG_HOME_AXIS4:  home_ff[4] <= clamp_pos(csr_wdata);
            REG_SEEK_TARGET: seek_ff    <= clamp_pos(csr_wdata);
            default: ;   // indexes past the register list are dropped
         endcase
      end
   end

   // One pass of command logic. On a tick every axis compares and steps in parallel; the
   // coupled motors only add a little pulse and direction logic after that.
   always_comb begin
      for (int i = 0; i < NUM_TARGETS; i++) begin
         target_in[i] = target_ff[i];
      end
      for (int i = 0; i < NUM_AXES; i++) begin
         position_in[i] = position_ff[i];
      end
      cal_in = cal_ff;
      dir_in = dir_ff;
      moving = '0;
      up_dir = '0;
      out_in = '0;

      unique case (s1_cmd_ff)
         CMD_TICK: begin
            for (int i = 0; i < NUM_AXES; i++) begin
               moving[i] = (target_ff[i] != position_ff[i]);
               up_dir[i] = (target_ff[i] > position_ff[i]);
               if (moving[i]) begin
                  position_in[i] = up_dir[i] ? position_ff[i] + position_type'(1)
                                             : position_ff[i] - position_type'(1);
                  dir_in[i] = up_dir[i];
               end
            end
            // Axis 2 also drives motor 5, but axis 4 has the last word on its pin.
            if (moving[2] && !moving[4]) begin
               dir_in[4] = up_dir[2];
            end
            out_in.servo_angle = to_field(target_ff[SERVO_AXIS]);
         end
         CMD_SET: begin
            if (s1_axis_ff < AXIS_BITS'(NUM_TARGETS)) begin
               target_in[s1_axis_ff] = clamp_pos(s1_value_ff);
            end
         end
         CMD_HOME: begin
            if (s1_axis_ff < AXIS_BITS'(NUM_AXES)) begin
               cal_in[s1_axis_ff]    = 1'b0;
               target_in[s1_axis_ff] = seek_ff;
            end
         end
         CMD_LIMIT: begin
            // A switch hit only counts while the axis is seeking home.
            if (s1_axis_ff < AXIS_BITS'(NUM_AXES) && !cal_ff[s1_axis_ff]) begin
               position_in[s1_axis_ff] = home_ff[s1_axis_ff];
               target_in[s1_axis_ff]   = home_ff[s1_axis_ff];
               cal_in[s1_axis_ff]      = 1'b1;
            end
         end
         default: ;
      endcase

      // Axis 2 gives motor 3 two pulses and motor 5 one; axis 4 gives motor 5 two.
      out_in.m1_pulses       = moving[0];
      out_in.m2_pulses       = moving[1];
      out_in.m3_pulses       = {moving[2], 1'b0};
      out_in.m4_pulses       = moving[3];
      out_in.m5_pulses       = {moving[4], moving[2]};
      out_in.dir_mask        = dir_in;
      out_in.calibrated_mask = cal_in;
      out_in.moving_mask     = moving;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TARGETS; i++) begin
            target_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_AXES; i++) begin
            position_ff[i] <= '0;
         end
         cal_ff <= '1;
         dir_ff <= '0;
      end else if (advance) begin
         for (int i = 0; i < NUM_TARGETS; i++) begin
            target_ff[i] <= target_in[i];
         end
         for (int i = 0; i < NUM_AXES; i++) begin
            position_ff[i] <= position_in[i];
         end
         cal_ff <= cal_in;
         dir_ff <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/mash_checker.sv
// Port-level checker for the stepper homing core, bound to the top level below.
// Uses mash_pkg for the stream widths.
`default_nettype none

module mash_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [mash_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import mash_pkg::*;

   rsp_type rsp;
   assign rsp = rsp_tdata;

   // A stalled result keeps its contents until the transfer completes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp payload changed while stalled");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // Single pulses follow the moving axes directly.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp.m1_pulses == rsp.moving_mask[0] &&
                     rsp.m2_pulses == rsp.moving_mask[1] &&
                     rsp.m4_pulses == rsp.moving_mask[3])
      else $error("direct motor pulses disagree with moving axes");

   // Coupled motors: axis 2 feeds motors 3 and 5, axis 4 feeds motor 5.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp.m3_pulses == {rsp.moving_mask[2], 1'b0} &&
                     rsp.m5_pulses == {rsp.moving_mask[4], rsp.moving_mask[2]})
      else $error("coupled motor pulses disagree with moving axes");

   // A result with no moving axis carries no pulses on the coupled motors.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.moving_mask == '0 |->
         rsp.m3_pulses == 2'd0 && rsp.m5_pulses == 2'd0)
      else $error("pulses issued with no axis moving");

endmodule

bind multi_axis_stepper_homing_core mash_checker u_mash_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
